FILE: design/kpsa_pkg.sv
// Shared types, constants and microcode program of the keyed partial shuffle block.
`default_nettype none

package kpsa_pkg;

    localparam int POOL_SIZE_DEF  = 26;
    localparam int DRAW_COUNT_DEF = 16;

    localparam int KEY_W = 64;
    localparam int MUL_W = 32;
    localparam int POS_W = 4;
    localparam int SYM_W = 7;

    localparam logic [KEY_W-1:0] GOLDEN   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [SYM_W-1:0] SYM_BASE = 7'd97;

    localparam int XS_SHL_A = 13;
    localparam int XS_SHR_B = 7;
    localparam int XS_SHL_C = 17;

    // Microprogram step addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] S_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] S_MUL_LL = 4'd1;
    localparam logic [UPC_W-1:0] S_MUL_LH = 4'd2;
    localparam logic [UPC_W-1:0] S_MUL_HL = 4'd3;
    localparam logic [UPC_W-1:0] S_ACC    = 4'd4;
    localparam logic [UPC_W-1:0] S_SEED   = 4'd5;
    localparam logic [UPC_W-1:0] S_XS     = 4'd6;
    localparam logic [UPC_W-1:0] S_DIV    = 4'd7;
    localparam logic [UPC_W-1:0] S_RD     = 4'd8;
    localparam logic [UPC_W-1:0] S_WAIT   = 4'd9;
    localparam logic [UPC_W-1:0] S_EMIT   = 4'd10;
    localparam logic [UPC_W-1:0] S_WRJ    = 4'd11;
    localparam logic [UPC_W-1:0] S_DONE   = 4'd12;

    typedef enum logic [2:0] {
        J_NONE       = 3'd0,
        J_ALWAYS     = 3'd1,
        J_NO_REQ     = 3'd2,
        J_DIV_MORE   = 3'd3,
        J_OUT_BUSY   = 3'd4,
        J_MORE_DRAWS = 3'd5
    } t_jcond;

    typedef enum logic [1:0] {
        MS_LL = 2'd0,
        MS_LH = 2'd1,
        MS_HL = 2'd2
    } t_msel;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD_HI = 2'd2
    } t_accop;

    // One control word
    typedef struct packed {
        t_jcond           jc;
        logic [UPC_W-1:0] target;
        logic             rdy;
        logic             clr;
        logic             mul_en;
        t_msel            msel;
        t_accop           acc;
        logic             seed;
        logic             xs;
        logic             div;
        logic             rd;
        logic             wr_i;
        logic             wr_j;
    } t_uword;

    // Datapath status used by jump conditions
    typedef struct packed {
        logic no_req;
        logic div_more;
        logic out_busy;
        logic more_draws;
    } t_cond;

    function automatic t_uword uc_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        w        = '0;
        w.jc     = J_NONE;
        w.target = S_IDLE;
        w.msel   = MS_LL;
        w.acc    = ACC_HOLD;
        case (addr)
            S_IDLE: begin
                w.rdy    = 1'b1;
                w.clr    = 1'b1;
                w.jc     = J_NO_REQ;
                w.target = S_IDLE;
            end
            S_MUL_LL: begin
                w.mul_en = 1'b1;
                w.msel   = MS_LL;
            end
            S_MUL_LH: begin
                w.mul_en = 1'b1;
                w.msel   = MS_LH;
                w.acc    = ACC_LOAD;
            end
            S_MUL_HL: begin
                w.mul_en = 1'b1;
                w.msel   = MS_HL;
                w.acc    = ACC_ADD_HI;
            end
            S_ACC: begin
                w.acc = ACC_ADD_HI;
            end
            S_SEED: begin
                w.seed = 1'b1;
            end
            S_XS: begin
                w.xs = 1'b1;
            end
            S_DIV: begin
                w.div    = 1'b1;
                w.jc     = J_DIV_MORE;
                w.target = S_DIV;
            end
            S_RD: begin
                w.rd = 1'b1;
            end
            S_WAIT: begin
                w.jc     = J_OUT_BUSY;
                w.target = S_WAIT;
            end
            S_EMIT: begin
                w.wr_i = 1'b1;
            end
            S_WRJ: begin
                w.wr_j   = 1'b1;
                w.jc     = J_MORE_DRAWS;
                w.target = S_XS;
            end
            S_DONE: begin
                w.jc     = J_ALWAYS;
                w.target = S_IDLE;
            end
            default: begin
                w.jc     = J_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [SYM_W-1:0] init_sym(input logic [SYM_W-1:0] k);
        return SYM_W'(SYM_BASE + k);
    endfunction

endpackage

`default_nettype wire

FILE: design/keyed_partial_shuffle_alphabet.sv
// Each accepted key runs the seed steps, then per result: xorshift step, bit-serial
//   remainder, pool read, wait, write of entry i with the emit, write of entry j.
// A new key is taken only once every draw of the previous key is through; the
//   bit-serial remainder unit, one state bit per cycle, sets how long that takes.
// Reset: synchronous, active low; returns the sequencer to idle, drops the result valid
//   and clears the pool valid bits. The block is ready for a key right after reset.
`default_nettype none

module keyed_partial_shuffle_alphabet #(
    parameter int POOL_SIZE  = kpsa_pkg::POOL_SIZE_DEF,
    parameter int DRAW_COUNT = kpsa_pkg::DRAW_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [kpsa_pkg::KEY_W-1:0]  i_salt_low,
    input  wire logic [kpsa_pkg::KEY_W-1:0]  i_salt_high,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [kpsa_pkg::POS_W-1:0]  o_position,
    output logic      [kpsa_pkg::SYM_W-1:0]  o_symbol,
    output logic                             o_last
);

    // Control flows one way: the sequencer reads status from the datapath and hands
    // back one control word per cycle. The program:
    //   idle (take a key request, clear the pool), three multiply steps and an
    //   accumulate for the seed, seed fixup, then per draw: xorshift, 64 remainder
    //   steps, pool read at i and j, wait for a free result register, write i and
    //   emit, write j and loop back while draws remain.
    kpsa_pkg::t_uword uword;
    kpsa_pkg::t_cond  cond;

    kpsa_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_uword (uword)
    );

    kpsa_dp #(
        .POOL_SIZE  (POOL_SIZE),
        .DRAW_COUNT (DRAW_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uword),
        .i_valid     (i_valid),
        .i_salt_low  (i_salt_low),
        .i_salt_high (i_salt_high),
        .i_ready     (i_ready),
        .o_cond      (cond),
        .o_valid     (o_valid),
        .o_position  (o_position),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    // Ready only in the idle step; the result register runs on its own, so a
    // pending last result does not hold off the next key.
    assign o_ready = uword.rdy;

endmodule

`default_nettype wire

FILE: design/kpsa_useq.sv
// Microprogram sequencer: step counter, control ROM and jump logic.
`default_nettype none

module kpsa_useq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire kpsa_pkg::t_cond i_cond,
    output kpsa_pkg::t_uword    o_uword
);

    logic [kpsa_pkg::UPC_W-1:0] r_upc;
    logic [kpsa_pkg::UPC_W-1:0] n_upc;
    kpsa_pkg::t_uword           uw;
    logic                       taken;

    assign uw      = kpsa_pkg::uc_rom(r_upc);
    assign o_uword = uw;

    always_comb begin
        case (uw.jc)
            kpsa_pkg::J_NONE:       taken = 1'b0;
            kpsa_pkg::J_ALWAYS:     taken = 1'b1;
            kpsa_pkg::J_NO_REQ:     taken = i_cond.no_req;
            kpsa_pkg::J_DIV_MORE:   taken = i_cond.div_more;
            kpsa_pkg::J_OUT_BUSY:   taken = i_cond.out_busy;
            kpsa_pkg::J_MORE_DRAWS: taken = i_cond.more_draws;
            default:                taken = 1'b0;
        endcase
        n_upc = taken ? uw.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= kpsa_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

FILE: design/kpsa_pool.sv
// Symbol pool memory with per-entry valid bits; unwritten entries read as their start letter.
`default_nettype none

module kpsa_pool #(
    parameter int POOL_SIZE = kpsa_pkg::POOL_SIZE_DEF,
    localparam int IW = $clog2(POOL_SIZE)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_clr,
    input  wire logic                        i_rd,
    input  wire logic [IW-1:0]               i_rd_addr_a,
    input  wire logic [IW-1:0]               i_rd_addr_b,
    input  wire logic                        i_wr,
    input  wire logic [IW-1:0]               i_wr_addr,
    input  wire logic [kpsa_pkg::SYM_W-1:0]  i_wr_data,
    output logic      [kpsa_pkg::SYM_W-1:0]  o_rd_a,
    output logic      [kpsa_pkg::SYM_W-1:0]  o_rd_b
);

    logic [kpsa_pkg::SYM_W-1:0] r_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0]       r_vld;
    logic [kpsa_pkg::SYM_W-1:0] r_rd_a;
    logic [kpsa_pkg::SYM_W-1:0] r_rd_b;

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_wr) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rd_a <= r_vld[i_rd_addr_a] ? r_mem[i_rd_addr_a]
                                         : kpsa_pkg::init_sym(kpsa_pkg::SYM_W'(i_rd_addr_a));
            r_rd_b <= r_vld[i_rd_addr_b] ? r_mem[i_rd_addr_b]
                                         : kpsa_pkg::init_sym(kpsa_pkg::SYM_W'(i_rd_addr_b));
        end
    end

endmodule

`default_nettype wire

FILE: design/kpsa_dp.sv
// Datapath: seed multiplier, xorshift, bit-serial remainder, swap and result register.
`default_nettype none

module kpsa_dp #(
    parameter int POOL_SIZE  = kpsa_pkg::POOL_SIZE_DEF,
    parameter int DRAW_COUNT = kpsa_pkg::DRAW_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire kpsa_pkg::t_uword            i_uword,
    input  wire logic                        i_valid,
    input  wire logic [kpsa_pkg::KEY_W-1:0]  i_salt_low,
    input  wire logic [kpsa_pkg::KEY_W-1:0]  i_salt_high,
    input  wire logic                        i_ready,
    output kpsa_pkg::t_cond                  o_cond,
    output logic                             o_valid,
    output logic      [kpsa_pkg::POS_W-1:0]  o_position,
    output logic      [kpsa_pkg::SYM_W-1:0]  o_symbol,
    output logic                             o_last
);

    localparam int KW     = kpsa_pkg::KEY_W;
    localparam int MW     = kpsa_pkg::MUL_W;
    localparam int IW     = $clog2(POOL_SIZE);
    localparam int LW     = $clog2(POOL_SIZE + 1);
    localparam int SW     = IW + 1;
    localparam int CNT_W  = $clog2(KW);
    localparam int DRAWS  = (DRAW_COUNT < POOL_SIZE) ? DRAW_COUNT : POOL_SIZE;
    localparam logic [IW-1:0]    LAST_I   = IW'(DRAWS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KW - 1);

    function automatic logic [KW-1:0] xs_next(input logic [KW-1:0] x);
        logic [KW-1:0] a;
        logic [KW-1:0] b;
        a = x ^ (x << kpsa_pkg::XS_SHL_A);
        b = a ^ (a >> kpsa_pkg::XS_SHR_B);
        return b ^ (b << kpsa_pkg::XS_SHL_C);
    endfunction

    logic [KW-1:0]    r_salt_lo;
    logic [KW-1:0]    r_salt_hi;
    logic [KW-1:0]    r_prod;
    logic [KW-1:0]    r_acc;
    logic [KW-1:0]    r_x;
    logic [KW-1:0]    r_dsh;
    logic [LW-1:0]    r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [IW-1:0]    r_i;
    logic [IW-1:0]    r_j;
    logic                       r_o_valid;
    logic [kpsa_pkg::POS_W-1:0] r_o_pos;
    logic [kpsa_pkg::SYM_W-1:0] r_o_sym;
    logic                       r_o_last;

    logic [MW-1:0]    mul_a;
    logic [MW-1:0]    mul_b;
    logic [KW-1:0]    prod_c;
    logic [KW-1:0]    seed_c;
    logic [KW-1:0]    xs_c;
    logic [LW-1:0]    left_c;
    logic [LW:0]      trial_c;
    logic [LW:0]      diff_c;
    logic [SW-1:0]    sum_c;
    logic [IW-1:0]    j_c;
    logic             out_free;
    logic [kpsa_pkg::SYM_W-1:0] rd_i;
    logic [kpsa_pkg::SYM_W-1:0] rd_j;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [kpsa_pkg::SYM_W-1:0] wr_data;

    // Shared 32x32 multiplier, low 64 bits of high * golden built from three products
    always_comb begin
        case (i_uword.msel)
            kpsa_pkg::MS_LL: begin
                mul_a = r_salt_hi[MW-1:0];
                mul_b = kpsa_pkg::GOLDEN[MW-1:0];
            end
            kpsa_pkg::MS_LH: begin
                mul_a = r_salt_hi[MW-1:0];
                mul_b = kpsa_pkg::GOLDEN[KW-1:MW];
            end
            kpsa_pkg::MS_HL: begin
                mul_a = r_salt_hi[KW-1:MW];
                mul_b = kpsa_pkg::GOLDEN[MW-1:0];
            end
            default: begin
                mul_a = r_salt_hi[MW-1:0];
                mul_b = kpsa_pkg::GOLDEN[MW-1:0];
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;
    assign seed_c = r_salt_lo ^ r_acc;
    assign xs_c   = xs_next(r_x);

    // Restoring remainder, one bit of the state per step
    assign left_c  = LW'(POOL_SIZE) - LW'(r_i);
    assign trial_c = {r_rem, r_dsh[KW-1]};
    assign diff_c  = trial_c - {1'b0, left_c};

    always_comb begin
        sum_c = SW'(r_i) + SW'(r_rem);
        if (sum_c >= SW'(POOL_SIZE)) begin
            j_c = IW'(POOL_SIZE - 1);
        end else begin
            j_c = sum_c[IW-1:0];
        end
    end

    assign out_free = !r_o_valid || i_ready;

    assign o_cond.no_req     = !i_valid;
    assign o_cond.div_more   = (r_cnt != CNT_LAST);
    assign o_cond.out_busy   = !out_free;
    assign o_cond.more_draws = (r_i != LAST_I);

    always_ff @(posedge i_clk) begin
        if (i_uword.clr) begin
            r_salt_lo <= i_salt_low;
            r_salt_hi <= i_salt_high;
        end
        if (i_uword.mul_en) begin
            r_prod <= prod_c;
        end
        case (i_uword.acc)
            kpsa_pkg::ACC_LOAD:   r_acc <= r_prod;
            kpsa_pkg::ACC_ADD_HI: r_acc <= r_acc + {r_prod[MW-1:0], {MW{1'b0}}};
            default:              r_acc <= r_acc;
        endcase
        if (i_uword.seed) begin
            r_x <= (seed_c == '0) ? kpsa_pkg::GOLDEN : seed_c;
        end else if (i_uword.xs) begin
            r_x <= xs_c;
        end
        if (i_uword.xs) begin
            r_dsh <= xs_c;
            r_rem <= '0;
        end else if (i_uword.div) begin
            r_dsh <= r_dsh << 1;
            r_rem <= (trial_c >= {1'b0, left_c}) ? diff_c[LW-1:0] : trial_c[LW-1:0];
        end
        if (i_uword.rd) begin
            r_j <= j_c;
        end
        if (i_uword.wr_i) begin
            r_o_pos  <= kpsa_pkg::POS_W'(r_i);
            r_o_sym  <= rd_j;
            r_o_last <= (r_i == LAST_I);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_i       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_uword.xs) begin
                r_cnt <= '0;
            end else if (i_uword.div) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_uword.clr) begin
                r_i <= '0;
            end else if (i_uword.wr_j) begin
                r_i <= r_i + 1'b1;
            end
            if (i_uword.wr_i) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Swap: entry i takes the value read at j, then entry j takes the old entry i
    assign wr_en   = i_uword.wr_i || i_uword.wr_j;
    assign wr_addr = i_uword.wr_i ? r_i : r_j;
    assign wr_data = i_uword.wr_i ? rd_j : rd_i;

    kpsa_pool #(
        .POOL_SIZE (POOL_SIZE)
    ) u_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (i_uword.clr),
        .i_rd        (i_uword.rd),
        .i_rd_addr_a (r_i),
        .i_rd_addr_b (j_c),
        .i_wr        (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_a      (rd_i),
        .o_rd_b      (rd_j)
    );

    assign o_valid    = r_o_valid;
    assign o_position = r_o_pos;
    assign o_symbol   = r_o_sym;
    assign o_last     = r_o_last;

endmodule

`default_nettype wire

FILE: design/kpsa_chk.sv
// Port-level checker for the keyed partial shuffle block, bound to the top level.
`default_nettype none

module kpsa_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_ready,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [kpsa_pkg::POS_W-1:0]  o_position,
    input wire logic [kpsa_pkg::SYM_W-1:0]  o_symbol,
    input wire logic                        o_last
);

    // Reset leaves the block idle and ready with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_ready && !o_valid))
        else $error("block not idle after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_position) && $stable(o_symbol) && $stable(o_last)))
        else $error("stalled result changed");

    // A key request starts a run, so ready drops next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after key request");

    // A taken result that is not the last leaves the run busy and no result
    // right behind it, since the next one needs a full remainder pass
    a_draw_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (!o_valid && !o_ready))
        else $error("result too soon or run ended early");

endmodule

bind keyed_partial_shuffle_alphabet kpsa_chk u_kpsa_chk (.*);

`default_nettype wire

FILE: tb/keyed_partial_shuffle_alphabet_test.sv
// Self-checking testbench for the keyed partial shuffle block: directed and random keys, random stalls.
module keyed_partial_shuffle_alphabet_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W = kpsa_pkg::KEY_W;
    localparam int POS_W = kpsa_pkg::POS_W;
    localparam int SYM_W = kpsa_pkg::SYM_W;
    localparam int POOL  = kpsa_pkg::POOL_SIZE_DEF;
    localparam int DRAWS = kpsa_pkg::DRAW_COUNT_DEF;

    localparam logic [KEY_W-1:0] GOLDEN = kpsa_pkg::GOLDEN;

    // Random part of the run; the directed keys come on top of this.
    localparam int RANDOM_KEYS = 306;

    // Idle rate of both sides, in percent, and a window with no idling at all.
    localparam int IDLE_PCT   = 28;
    localparam int CALM_FIRST = 100_000;
    localparam int CALM_LAST  = 160_000;

    // Settle time after the last result, well over one draw of the block.
    localparam int DRAIN_CYCLES = 200;

    // Time limit for the whole run, in ns, well above what a clean run needs.
    localparam int RUN_LIMIT_NS = 4_000_000;

    localparam logic [KEY_W-1:0] ALL_ONES = '1;

    // One key request: both 64-bit halves.
    typedef struct packed {
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
    } t_key;

    // One drawn letter as the block reports it.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_draw;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic [KEY_W-1:0] i_salt_low  = '0;
    logic [KEY_W-1:0] i_salt_high = '0;
    logic             i_ready     = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [POS_W-1:0] o_position;
    logic [SYM_W-1:0] o_symbol;
    logic             o_last;

    t_key  pending_keys[$];
    t_draw expected_draws[$];
    int    cycle_count = 0;
    int    fail_count  = 0;

    keyed_partial_shuffle_alphabet dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_salt_low  (i_salt_low),
        .i_salt_high (i_salt_high),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_position  (o_position),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Roll whether a side sits out this cycle; never inside the calm window.
    function automatic bit idle_roll();
        if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Run the keyed shuffle for one key and queue every letter it should emit.
    // Seed is low XOR (high times the golden constant), with zero forced to the
    // constant; each draw steps xorshift, picks j in [i, POOL) and swaps.
    function automatic void predict_shuffle(input logic [KEY_W-1:0] key_lo,
                                            input logic [KEY_W-1:0] key_hi);
        logic [KEY_W-1:0] x;
        logic [SYM_W-1:0] letters [POOL];
        logic [SYM_W-1:0] held;
        int               draw_total;
        int               j;
        t_draw            d;
        for (int k = 0; k < POOL; k++) begin
            letters[k] = SYM_W'(kpsa_pkg::SYM_BASE + SYM_W'(k));
        end
        x = key_lo ^ KEY_W'(key_hi * GOLDEN);
        if (x == '0) begin
            x = GOLDEN;
        end
        draw_total = (DRAWS < POOL) ? DRAWS : POOL;
        for (int i = 0; i < draw_total; i++) begin
            x = x ^ (x << kpsa_pkg::XS_SHL_A);
            x = x ^ (x >> kpsa_pkg::XS_SHR_B);
            x = x ^ (x << kpsa_pkg::XS_SHL_C);
            j = i + int'(x % KEY_W'(POOL - i));
            if (j >= POOL) begin
                j = POOL - 1;
            end
            held       = letters[i];
            letters[i] = letters[j];
            letters[j] = held;
            d.position = POS_W'(i);
            d.symbol   = letters[i];
            d.last     = (i == draw_total - 1);
            expected_draws.push_back(d);
        end
    endfunction

    task automatic queue_key(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
        t_key k;
        k.lo = lo;
        k.hi = hi;
        pending_keys.push_back(k);
    endtask

    // Driver: hold the request until it is taken, then predict it and move on.
    // Only one nonblocking write to i_valid per edge, so a back-to-back
    // request keeps valid high without a glitch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                predict_shuffle(i_salt_low, i_salt_high);
                void'(pending_keys.pop_front());
            end
            if (pending_keys.size() != 0 && !idle_roll()) begin
                i_valid     <= 1'b1;
                i_salt_low  <= pending_keys[0].lo;
                i_salt_high <= pending_keys[0].hi;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted letter against the oldest prediction,
    // then roll the stall for the next cycle.
    always @(posedge i_clk) begin : result_check
        t_draw want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_draws.size() == 0) begin
                    $error("unexpected result: position %0d symbol %0d last %0b",
                           o_position, o_symbol, o_last);
                    fail_count++;
                end else begin
                    want = expected_draws.pop_front();
                    if (o_position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, o_position);
                        fail_count++;
                    end
                    if (o_symbol !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol, o_symbol);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            i_ready <= !idle_roll();
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;

        // Directed keys: zero seed in its three forms, smallest and largest
        // seeds, field extremes and alternating bit patterns.
        queue_key('0, '0);
        queue_key(GOLDEN, 64'd1);
        queue_key(KEY_W'(ALL_ONES * GOLDEN), ALL_ONES);
        queue_key(GOLDEN ^ 64'd1, 64'd1);
        queue_key(~GOLDEN, 64'd1);
        queue_key(ALL_ONES, ALL_ONES);
        queue_key(ALL_ONES, '0);
        queue_key('0, ALL_ONES);
        queue_key(64'd1, '0);
        queue_key('0, 64'd1);
        queue_key(64'h8000_0000_0000_0000, '0);
        queue_key('0, 64'h8000_0000_0000_0000);
        queue_key(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_key(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

        // Random keys: mostly dense, some with a zero half, some sparse,
        // and an occasional key that folds to a zero seed.
        repeat (RANDOM_KEYS) begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            case ($urandom_range(9))
                0: hi = '0;
                1: lo = '0;
                2: begin
                    hi = KEY_W'(1) << $urandom_range(KEY_W - 1);
                    lo = KEY_W'(1) << $urandom_range(KEY_W - 1);
                end
                3: lo = KEY_W'(hi * GOLDEN);
                default: ;
            endcase
            queue_key(lo, hi);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every letter to come out.
        while (pending_keys.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Timeout: a hung block or a missing result ends up here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
